>>> design/cpd_pkg.sv
package cpd_pkg;

  localparam int NUM_PADS_DEF = 3;
  localparam int CountW = 16;
  localparam int IdxW = 2;
  localparam logic [CountW-1:0] THRESH_RST = 16'd100;

  typedef struct packed {
    logic [IdxW-1:0]   button_index;
    logic [CountW-1:0] measured_count;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]   pad_index;
    logic              press_event;
    logic              release_event;
    logic              is_pressed;
    logic [CountW-1:0] drop_amount;
  } out_item_t;

  // decision for one pad, from the evaluator to the state update
  typedef struct packed {
    logic              base_we;
    logic [CountW-1:0] base_nxt;
    logic              pressed;
    logic              press;
    logic              release_ev;
    logic [CountW-1:0] drop;
  } pad_eval_t;

endpackage

>>> design/cpd_in_if.sv
interface cpd_in_if import cpd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/cpd_out_if.sv
interface cpd_out_if import cpd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/captouch_baseline_press_detect.sv
// Capacitive touch press detector. Each item carries a pad index and the
// oscillation count measured on that pad. Per pad the block keeps a baseline
// and a pressed flag. A count above the baseline pulls the baseline to the
// floor of their average and reports zero drop; otherwise drop is baseline
// minus count. A drop strictly above cfg press_threshold (reset 100) marks the
// pad pressed, with press_event on the transition; a drop at or below it
// clears a set flag with release_event. Pad indexes at or above NUM_PADS
// touch no state and return zeros apart from the echoed index. Exactly one
// result per item. The accepting edge loads the input register; one pass
// through the pad evaluator loads the result register once that register is
// free or being taken, with the pad state written on that same edge.
// One item is accepted every cycle as long as the result side keeps up;
// ready drops only when both the input register and the result register are
// full.
// press_threshold is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, and the block does not enforce that.
module captouch_baseline_press_detect import cpd_pkg::*; #(
  parameter int NUM_PADS = NUM_PADS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  cpd_in_if.sink            in_ch,
  cpd_out_if.source         out_ch,
  input  logic              cfg_wr_en,
  input  logic [CountW-1:0] cfg_wr_data
);

  localparam int PadW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
  localparam logic [4:0] NumPadsL = 5'(NUM_PADS);

  // configuration
  logic [CountW-1:0] thresh_r;

  // input register
  logic              s1_valid_r;
  in_item_t          s1_data_r;

  // result register
  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         out_data_nxt;

  // per pad state
  logic [CountW-1:0] base_r [NUM_PADS];
  logic [NUM_PADS-1:0] pressed_r;

  logic              adv;
  logic              move;
  logic              in_range;
  logic [PadW-1:0]   pad_sel;
  pad_eval_t         ev;

  // result slot frees when empty or being taken this cycle
  assign adv  = ~out_valid_r | out_ch.ready;
  assign move = s1_valid_r & adv;

  assign in_ch.ready  = ~s1_valid_r | adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign in_range = {3'b000, s1_data_r.button_index} < NumPadsL;
  assign pad_sel  = PadW'(s1_data_r.button_index);

  cpd_pad_eval u_eval (
    .base        (in_range ? base_r[pad_sel] : '0),
    .was_pressed (in_range ? pressed_r[pad_sel] : 1'b0),
    .count       (s1_data_r.measured_count),
    .thresh      (thresh_r),
    .res         (ev)
  );

  always_comb begin
    out_data_nxt.pad_index     = s1_data_r.button_index;
    out_data_nxt.press_event   = in_range & ev.press;
    out_data_nxt.release_event = in_range & ev.release_ev;
    out_data_nxt.is_pressed    = in_range & ev.pressed;
    out_data_nxt.drop_amount   = in_range ? ev.drop : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_data_r <= in_ch.data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r <= out_data_nxt;
    end
  end

  // pad state, written on the edge the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PADS; i++) begin
        base_r[i] <= '0;
      end
      pressed_r <= '0;
    end else if (move && in_range) begin
      if (ev.base_we) begin
        base_r[pad_sel] <= ev.base_nxt;
      end
      pressed_r[pad_sel] <= ev.pressed;
    end
  end

  // never a press and a release for the same item
  a_no_both_events: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.press_event && out_data_r.release_event))
    else $error("press and release on one item");

  // events agree with the reported flag
  a_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.press_event || out_data_r.release_event)
      |-> (out_data_r.is_pressed == out_data_r.press_event))
    else $error("event disagrees with pressed flag");

  // out of range pads report nothing
  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ({3'b000, out_data_r.pad_index} >= NumPadsL)
      |-> (!out_data_r.is_pressed && !out_data_r.press_event
           && !out_data_r.release_event && out_data_r.drop_amount == '0))
    else $error("out of range pad reported activity");

  // an item that moves forward shows up as a result next cycle
  a_move_lands: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid_r)
    else $error("item lost between input and result register");

endmodule

>>> design/cpd_pad_eval.sv
module cpd_pad_eval import cpd_pkg::*; (
  input  logic [CountW-1:0] base,
  input  logic              was_pressed,
  input  logic [CountW-1:0] count,
  input  logic [CountW-1:0] thresh,
  output pad_eval_t         res
);

  logic              rose;
  logic [CountW:0]   sum;
  logic [CountW-1:0] drop;
  logic              above;

  always_comb begin
    rose  = count > base;
    sum   = {1'b0, base} + {1'b0, count};
    drop  = rose ? '0 : (base - count);
    above = drop > thresh;

    res.base_we    = rose;
    res.base_nxt   = sum[CountW:1];
    res.pressed    = above;
    res.press      = above & ~was_pressed;
    res.release_ev = ~above & was_pressed;
    res.drop       = drop;
  end

endmodule

>>> tb/sv/tb_captouch_baseline_press_detect.sv
`timescale 1ns / 100ps

module tb_captouch_baseline_press_detect import cpd_pkg::*;;

  localparam int PadCount = NUM_PADS_DEF;
  localparam int IdleMax = 9;
  localparam int DrainLimit = 5000;
  // extra wait once every expected result is back
  localparam int SettleCycles = 4;
  localparam int PhaseItems = 205;
  localparam int HoldCycles = 60;

  // predicts pad state and keeps the expected results in order
  class press_scoreboard;
    logic [CountW-1:0] baseline_q [PadCount];
    logic              pressed_q [PadCount];
    logic [CountW-1:0] threshold;
    out_item_t         expected_q [$];
    int unsigned       errors;

    function new();
      for (int i = 0; i < PadCount; i++) begin
        baseline_q[i] = '0;
        pressed_q[i] = 1'b0;
      end
      threshold = THRESH_RST;
      errors = 0;
    endfunction

    function void set_threshold(logic [CountW-1:0] value);
      threshold = value;
    endfunction

    task report(string msg);
      if (errors < 50) $display("mismatch: %s", msg);
      errors++;
    endtask

    // work out the result of one accepted item and queue it
    function void note_input(in_item_t item);
      out_item_t         res;
      logic [CountW:0]   wide_sum;
      logic [CountW-1:0] base;
      int                pad;
      res = '0;
      pad = item.button_index;
      res.pad_index = item.button_index;
      if (pad < PadCount) begin
        base = baseline_q[pad];
        if (item.measured_count > base) begin
          // 17-bit sum, then halve, so the average never wraps
          wide_sum = {1'b0, base} + {1'b0, item.measured_count};
          baseline_q[pad] = wide_sum[CountW:1];
          res.drop_amount = '0;
        end else begin
          res.drop_amount = base - item.measured_count;
        end
        if (res.drop_amount > threshold) begin
          if (!pressed_q[pad]) begin
            pressed_q[pad] = 1'b1;
            res.press_event = 1'b1;
          end
        end else if (pressed_q[pad]) begin
          pressed_q[pad] = 1'b0;
          res.release_event = 1'b1;
        end
        res.is_pressed = pressed_q[pad];
      end
      expected_q.push_back(res);
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with nothing expected", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.pad_index !== want.pad_index)
        report($sformatf("pad_index got %0d want %0d", got.pad_index, want.pad_index));
      if (got.press_event !== want.press_event)
        report($sformatf("pad %0d press_event got %b want %b",
                         want.pad_index, got.press_event, want.press_event));
      if (got.release_event !== want.release_event)
        report($sformatf("pad %0d release_event got %b want %b",
                         want.pad_index, got.release_event, want.release_event));
      if (got.is_pressed !== want.is_pressed)
        report($sformatf("pad %0d is_pressed got %b want %b",
                         want.pad_index, got.is_pressed, want.is_pressed));
      if (got.drop_amount !== want.drop_amount)
        report($sformatf("pad %0d drop_amount got %h want %h",
                         want.pad_index, got.drop_amount, want.drop_amount));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CountW-1:0] cfg_wr_data;

  cpd_in_if  in_ch ();
  cpd_out_if out_ch ();

  press_scoreboard sb;

  // idle limits per side, and a long result hold-off request
  int unsigned tx_max;
  int unsigned rx_max;
  int unsigned hold_cycles;

  captouch_baseline_press_detect DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // handshakes are sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end
  end

  // offer one item after a random gap, return at the falling edge after acceptance
  // valid stays high so a follow-up item with no gap goes out back to back
  task automatic send_item(int unsigned pad, int unsigned count);
    int unsigned gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data.button_index = pad[IdxW-1:0];
    in_ch.data.measured_count = count[CountW-1:0];
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_idle();
    int unsigned n;
    n = 0;
    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0 && n < DrainLimit) begin
      @(negedge clk);
      n++;
    end
    repeat (SettleCycles) @(negedge clk);
  endtask

  // only called while the block is idle
  task automatic write_threshold(logic [CountW-1:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_threshold(value);
  endtask

  // pick a count around the pad's predicted baseline so presses, holds and
  // releases all come up; a share of fully random counts and bad pad indexes
  task automatic send_touch();
    int unsigned pad;
    int unsigned base;
    int unsigned thr;
    int unsigned span;
    int unsigned count;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    thr = sb.threshold;
    pad = ($urandom_range(0, 19) == 0) ? PadCount : $urandom_range(0, PadCount - 1);
    if (pad < PadCount) base = sb.baseline_q[pad];
    else base = $urandom_range(0, 65535);
    if (pick < 15) begin
      count = $urandom_range(0, 65535);
    end else if (pick < 35) begin
      // count rises, baseline follows
      count = base + $urandom_range(0, 400);
      if (count > 65535) count = 65535;
    end else if (pick < 45 && base > thr) begin
      // drop right at the threshold or one above it
      count = base - thr - $urandom_range(0, 1);
    end else begin
      span = (thr > 2000) ? base : thr * 2 + 4;
      if (span > base) span = base;
      count = base - $urandom_range(0, span);
    end
    send_item(pad, count);
  endtask

  // result side: random stall before each item, plus long hold-offs on request
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      stall = $urandom_range(0, rx_max);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [CountW-1:0] thresholds [8];
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    rst_n = 1'b0;
    tx_max = IdleMax;
    rx_max = IdleMax;
    hold_cycles = 0;
    sb = new();

    // extremes first, then mid values and random picks
    thresholds[0] = '0;
    thresholds[1] = '1;
    thresholds[2] = 16'd1;
    thresholds[3] = CountW'($urandom_range(0, 65535));
    thresholds[4] = 16'd100;
    thresholds[5] = CountW'($urandom_range(0, 500));
    thresholds[6] = 16'd1000;
    thresholds[7] = CountW'($urandom_range(0, 65535));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset threshold of 100
    send_item(0, 16'hFFFF);            // baseline from zero to half scale
    send_item(0, 16'hFFFF);            // sum needs the 17th bit
    send_item(0, 16'hBFFF);            // count equal to baseline
    send_item(0, 16'hBFFF - 101);      // just over threshold: press
    send_item(0, 16'hBFFF - 101);      // still pressed, no event
    send_item(0, 16'hBFFF - 100);      // at threshold: release
    send_item(0, 16'h0000);            // biggest drop: press
    send_item(0, 16'hBFFF);            // back to baseline: release
    send_item(PadCount, 16'h0000);     // bad pad index
    send_item(PadCount, 16'hFFFF);
    send_item(1, 16'h5555);
    send_item(1, 16'hAAAA);
    send_item(1, 16'h0000);            // press on a second pad
    send_item(2, 16'h0001);
    send_item(2, 16'h0000);
    send_item(2, 16'h0003);            // average rounds down
    send_item(1, 16'h6AAA);            // release
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      write_threshold(thresholds[ph]);
      // every third phase runs with no idling on either side
      tx_max = (ph % 3 == 1) ? 0 : IdleMax;
      rx_max = (ph % 3 == 1) ? 0 : IdleMax;
      if (ph == 0) begin
        send_item(2, 16'h0000);        // drop of one presses at threshold zero
        send_item(2, 16'h0001);
      end
      if (ph == 1) send_item(0, 16'h0000);  // no drop exceeds full-scale threshold
      for (int i = 0; i < PhaseItems; i++) begin
        // long result hold-off while items keep coming, so the input stalls
        if (ph == 4 && (i == 0 || i == 120)) hold_cycles = HoldCycles;
        // sender pauses until everything is back
        if (ph == 3 && i == 100) wait_idle();
        send_touch();
      end
      wait_idle();
    end

    wait_idle();
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("tb_captouch_baseline_press_detect OK");
    end else begin
      $display("tb_captouch_baseline_press_detect NOT OK");
    end
    $finish;
  end

  // far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("tb_captouch_baseline_press_detect NOT OK");
    $finish;
  end

endmodule
